FILE: design/taps_pkg.sv
// Package for the two-axis pick sequencer: phase codes, register indexes, payload types.
`default_nettype none
package taps_pkg;

    localparam int POS_FIELD_BITS = 12;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_CENTRE  = 4'd1,
        PH_JOG     = 4'd2,
        PH_LOWER   = 4'd3,
        PH_GRIP    = 4'd4,
        PH_RAISE   = 4'd5,
        PH_DONE    = 4'd6,
        PH_HOME    = 4'd7,
        PH_RELEASE = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        GRIP_RELEASED = 2'd0,
        GRIP_LOW      = 2'd1,
        GRIP_HIGH     = 2'd2
    } grip_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_LIMIT     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_CENTRE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_PER_JOG   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_PER_TRAV  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_PER_DOWN  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_PER_UP    = 3'd6;

    typedef struct packed {
        logic       master_level;
        logic       button_forward;
        logic       button_back;
        logic [3:0] grip_roll;
    } in_item_t;

    typedef struct packed {
        logic [3:0]                phase;
        logic [POS_FIELD_BITS-1:0] y_position;
        logic [POS_FIELD_BITS-1:0] z_position;
        logic                      y_step_pulse;
        logic                      y_direction;
        logic                      z_step_pulse;
        logic                      z_direction;
        logic                      done_level;
        logic [1:0]                grip_drive;
    } out_item_t;

endpackage
`default_nettype wire

FILE: design/two_axis_pick_sequencer.sv
// Two-axis pick sequencer: phase control, step timers and result register.
//
// Usage: each transfer on the input channel (in_valid, in_stall, in_data) is one
// microsecond tick carrying the master level, the two debounced buttons and a
// torque roll. Every accepted tick yields exactly one result transfer on the
// output channel (out_valid, out_stall, out_data) with the phase, both axis
// positions, the step pulses and directions, the done level and the solenoid
// command as they stand after that tick.
// The result is valid in the cycle after the input transfer.
// Throughput: one tick per cycle if not stalled; the phase update and both
// axis timers run in one pass from the state registers to the result register.
// A stalled result stays in the result register; in_stall is raised only while
// that result is held, and a new tick is taken in the cycle the result leaves.
// Reset (rst_n low) puts the sequencer in idle at position zero with the
// solenoid released and loads the default limits and periods. Registers are
// written by the user through cfg_we/cfg_index/cfg_data in idle; unchecked.
`default_nettype none
module two_axis_pick_sequencer #(
    parameter int POSITION_BITS = 12,
    parameter int TIMER_BITS    = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire taps_pkg::in_item_t                    in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output taps_pkg::out_item_t                        out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [taps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [((TIMER_BITS > POSITION_BITS) ? TIMER_BITS : POSITION_BITS)-1:0]
                                                       cfg_data
);

    logic [POSITION_BITS-1:0] y_limit_reg, y_centre_reg, z_limit_reg;
    logic [TIMER_BITS-1:0]    y_per_jog_reg, y_per_trav_reg, z_per_down_reg, z_per_up_reg;

    taps_pkg::phase_t         phase_reg, phase_next;
    logic                     entry_reg, entry_next;
    logic [POSITION_BITS-1:0] y_count_reg, y_count_next, z_count_reg, z_count_next;
    logic [TIMER_BITS-1:0]    y_timer_reg, y_timer_next, z_timer_reg, z_timer_next;
    logic                     strong_reg, strong_next;
    logic                     done_reg, done_next;
    taps_pkg::grip_t          grip_reg, grip_next;

    logic                     out_valid_reg;
    taps_pkg::out_item_t      out_data_reg, out_data_next;

    logic                     accept;
    logic                     y_up, y_dn, z_dn, z_up;
    logic                     y_pulse, z_pulse;
    logic [TIMER_BITS-1:0]    y_timer_inc, z_timer_inc, y_per, z_per;
    logic [POSITION_BITS+taps_pkg::POS_FIELD_BITS-1:0] y_ext, z_ext;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_limit_reg    <= POSITION_BITS'(2750);
            y_centre_reg   <= POSITION_BITS'(1375);
            z_limit_reg    <= POSITION_BITS'(1000);
            y_per_jog_reg  <= TIMER_BITS'(1000);
            y_per_trav_reg <= TIMER_BITS'(1000);
            z_per_down_reg <= TIMER_BITS'(4000);
            z_per_up_reg   <= TIMER_BITS'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                taps_pkg::CFG_Y_LIMIT:    y_limit_reg    <= cfg_data[POSITION_BITS-1:0];
                taps_pkg::CFG_Y_CENTRE:   y_centre_reg   <= cfg_data[POSITION_BITS-1:0];
                taps_pkg::CFG_Z_LIMIT:    z_limit_reg    <= cfg_data[POSITION_BITS-1:0];
                taps_pkg::CFG_Y_PER_JOG:  y_per_jog_reg  <= cfg_data[TIMER_BITS-1:0];
                taps_pkg::CFG_Y_PER_TRAV: y_per_trav_reg <= cfg_data[TIMER_BITS-1:0];
                taps_pkg::CFG_Z_PER_DOWN: z_per_down_reg <= cfg_data[TIMER_BITS-1:0];
                taps_pkg::CFG_Z_PER_UP:   z_per_up_reg   <= cfg_data[TIMER_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    // One tick of the sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        strong_next = strong_reg;
        done_next   = done_reg;
        grip_next   = grip_reg;
        y_up        = 1'b0;
        y_dn        = 1'b0;
        z_dn        = 1'b0;
        z_up        = 1'b0;
        y_per       = y_per_trav_reg;
        z_per       = z_per_up_reg;

        y_timer_inc = (&y_timer_reg) ? y_timer_reg : y_timer_reg + TIMER_BITS'(1);
        z_timer_inc = (&z_timer_reg) ? z_timer_reg : z_timer_reg + TIMER_BITS'(1);

        unique case (phase_reg)
            taps_pkg::PH_IDLE:
            begin
                if (in_data.master_level)
                    phase_next = taps_pkg::PH_CENTRE;
            end
            taps_pkg::PH_CENTRE:
            begin
                if (y_count_reg < y_centre_reg)
                    y_up = 1'b1;
                else if (y_count_reg > y_centre_reg)
                    y_dn = 1'b1;
                else if (!in_data.master_level)
                    phase_next = taps_pkg::PH_JOG;
            end
            taps_pkg::PH_JOG:
            begin
                y_per = y_per_jog_reg;
                if (in_data.button_back)
                    y_up = (y_count_reg < y_limit_reg);
                else if (in_data.button_forward)
                    y_dn = (y_count_reg != '0);
                if (in_data.master_level)
                    phase_next = taps_pkg::PH_LOWER;
            end
            taps_pkg::PH_LOWER:
            begin
                z_per = z_per_down_reg;
                if (entry_reg)
                    strong_next = (in_data.grip_roll == 4'd0);
                if (z_count_reg < z_limit_reg)
                    z_dn = 1'b1;
                else
                    phase_next = taps_pkg::PH_GRIP;
            end
            taps_pkg::PH_GRIP:
            begin
                if (entry_reg)
                    grip_next = strong_reg ? taps_pkg::GRIP_HIGH : taps_pkg::GRIP_LOW;
                phase_next = taps_pkg::PH_RAISE;
            end
            taps_pkg::PH_RAISE:
            begin
                if (z_count_reg != '0)
                    z_up = 1'b1;
                else
                    phase_next = taps_pkg::PH_DONE;
            end
            taps_pkg::PH_DONE:
            begin
                if (entry_reg)
                    done_next = 1'b1;
                if (!in_data.master_level)
                begin
                    done_next  = 1'b0;
                    phase_next = taps_pkg::PH_HOME;
                end
            end
            taps_pkg::PH_HOME:
            begin
                if (y_count_reg != '0)
                    y_dn = 1'b1;
                else
                    phase_next = taps_pkg::PH_RELEASE;
            end
            taps_pkg::PH_RELEASE:
            begin
                grip_next  = taps_pkg::GRIP_RELEASED;
                phase_next = taps_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = taps_pkg::PH_IDLE;
            end
        endcase

        y_pulse      = (y_up || y_dn) && (y_timer_inc >= y_per);
        z_pulse      = (z_up || z_dn) && (z_timer_inc >= z_per);
        y_timer_next = y_pulse ? '0 : y_timer_inc;
        z_timer_next = z_pulse ? '0 : z_timer_inc;
        y_count_next = !y_pulse ? y_count_reg
                     : (y_up ? y_count_reg + POSITION_BITS'(1) : y_count_reg - POSITION_BITS'(1));
        z_count_next = !z_pulse ? z_count_reg
                     : (z_dn ? z_count_reg + POSITION_BITS'(1) : z_count_reg - POSITION_BITS'(1));
        entry_next   = (phase_next != phase_reg);

        y_ext = {{taps_pkg::POS_FIELD_BITS{1'b0}}, y_count_next};
        z_ext = {{taps_pkg::POS_FIELD_BITS{1'b0}}, z_count_next};

        out_data_next.phase        = phase_next;
        out_data_next.y_position   = y_ext[taps_pkg::POS_FIELD_BITS-1:0];
        out_data_next.z_position   = z_ext[taps_pkg::POS_FIELD_BITS-1:0];
        out_data_next.y_step_pulse = y_pulse;
        out_data_next.y_direction  = y_up;
        out_data_next.z_step_pulse = z_pulse;
        out_data_next.z_direction  = z_dn;
        out_data_next.done_level   = done_next;
        out_data_next.grip_drive   = grip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= taps_pkg::PH_IDLE;
            entry_reg     <= 1'b1;
            y_count_reg   <= '0;
            z_count_reg   <= '0;
            y_timer_reg   <= '0;
            z_timer_reg   <= '0;
            strong_reg    <= 1'b0;
            done_reg      <= 1'b0;
            grip_reg      <= taps_pkg::GRIP_RELEASED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                entry_reg   <= entry_next;
                y_count_reg <= y_count_next;
                z_count_reg <= z_count_next;
                y_timer_reg <= y_timer_next;
                z_timer_reg <= z_timer_next;
                strong_reg  <= strong_next;
                done_reg    <= done_next;
                grip_reg    <= grip_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // done is only ever reported while in the done phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_level |-> out_data.phase == taps_pkg::PH_DONE)
        else $error("done level outside done phase");

    // a downward Z step keeps the sequencer lowering
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.z_step_pulse && out_data.z_direction
        |-> out_data.phase == taps_pkg::PH_LOWER)
        else $error("Z lowering step outside lower phase");

    // solenoid command stays a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.grip_drive == taps_pkg::GRIP_RELEASED
                    || out_data.grip_drive == taps_pkg::GRIP_LOW
                    || out_data.grip_drive == taps_pkg::GRIP_HIGH))
        else $error("undefined grip command");

    // an accepted tick always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transfer produced no result");
`endif

endmodule
`default_nettype wire
